/* hdl/rrip_pkg.sv */
// ----------------------------------------------------------------------------
// rrip_pkg
// Shared types and constants for the RRIP replacement core with reuse
// predictor: defaults, RRPV and predictor codes, controller state and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rrip_pkg;

  // default geometry
  localparam int unsigned NUM_SETS_DEF = 2048;
  localparam int unsigned NUM_WAYS_DEF = 16;
  localparam int unsigned SIG_BITS_DEF = 15;

  // fixed field widths
  localparam int unsigned EPOCH_W  = 21;
  localparam int unsigned SET_IN_W = 11;
  localparam int unsigned WAY_IN_W = 4;
  localparam int unsigned PC_IN_W  = 15;

  localparam logic [EPOCH_W-1:0] EPOCH_RESET = 21'd32768;

  // RRPV and predictor codes
  localparam logic [1:0] RRPV_NEAR    = 2'd0;
  localparam logic [1:0] RRPV_LONG    = 2'd2;
  localparam logic [1:0] RRPV_DISTANT = 2'd3;
  localparam logic [1:0] PRED_TOP     = 2'd3;
  localparam logic [1:0] PRED_BOTTOM  = 2'd0;
  localparam logic [1:0] PRED_START   = 2'd2;
  localparam logic [1:0] THR_RESET    = 2'd2;

  // item kinds
  localparam logic KIND_VICTIM = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ROW,
    S_PRED,
    S_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic row_step;
    logic pred_step;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic is_victim;
    logic out_free;
  } sts_t;

endpackage

/* hdl/rrip_ctrl.sv */
// ----------------------------------------------------------------------------
// rrip_ctrl
// Sequencer: clearing sweep after reset, then per item a set-row step, an
// optional predictor write step for victims, and the result hand-off.
// ----------------------------------------------------------------------------
module rrip_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rrip_pkg::sts_t sts_i,
  output rrip_pkg::cmd_t cmd_o
);
  import rrip_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (sts_i.clear_last) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_ROW;
      S_ROW:   state_d = sts_i.is_victim ? S_PRED : S_DONE;
      S_PRED:  state_d = S_DONE;
      S_DONE:  if (sts_i.out_free) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o           = '0;
    in_stall_o      = 1'b1;
    unique case (state_q)
      S_CLEAR: cmd_o.clear = 1'b1;
      S_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      S_ROW:   cmd_o.row_step  = 1'b1;
      S_PRED:  cmd_o.pred_step = 1'b1;
      S_DONE:  cmd_o.load_out  = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

/* hdl/rrip_datapath.sv */
// ----------------------------------------------------------------------------
// rrip_datapath
// Set metadata and predictor memories, ageing and victim search, predictor
// training, epoch threshold adaptation and the output register.
// ----------------------------------------------------------------------------
module rrip_datapath #(
  parameter int unsigned NUM_SETS = rrip_pkg::NUM_SETS_DEF,
  parameter int unsigned NUM_WAYS = rrip_pkg::NUM_WAYS_DEF,
  parameter int unsigned SIG_BITS = rrip_pkg::SIG_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rrip_pkg::cmd_t                cmd_i,
  output rrip_pkg::sts_t                sts_o,
  input  logic                          kind_i,
  input  logic [rrip_pkg::SET_IN_W-1:0] set_index_i,
  input  logic [rrip_pkg::WAY_IN_W-1:0] way_i,
  input  logic                          hit_i,
  input  logic [rrip_pkg::PC_IN_W-1:0]  pc_signature_i,
  input  logic                          cfg_valid_i,
  input  logic [rrip_pkg::EPOCH_W-1:0]  cfg_epoch_length_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [3:0]                    victim_way_o,
  output logic [1:0]                    threshold_o
);
  import rrip_pkg::*;

  localparam int unsigned SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned WAY_W    = $clog2(NUM_WAYS);
  localparam int unsigned PRED_N   = 1 << SIG_BITS;
  localparam int unsigned CLR_W    = (SET_W > SIG_BITS) ? SET_W : SIG_BITS;
  localparam int unsigned CLR_N    = (NUM_SETS > PRED_N) ? NUM_SETS : PRED_N;
  localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_N - 1);
  localparam logic [CLR_W:0]   CLR_SETS = (CLR_W + 1)'(NUM_SETS);

  typedef logic [NUM_WAYS-1:0][1:0]          rrpv_row_t;
  typedef logic [NUM_WAYS-1:0]               reuse_row_t;
  typedef logic [NUM_WAYS-1:0][SIG_BITS-1:0] sig_row_t;

  // set index modulo the set count, by shifted compare and subtract
  function automatic logic [SET_W-1:0] set_mod(input logic [SET_IN_W-1:0] x);
    logic [27:0] r;
    r = 28'(x);
    for (int k = SET_IN_W - 1; k >= 0; k--) begin
      if (r >= (28'(NUM_SETS) << k)) r = r - (28'(NUM_SETS) << k);
    end
    return r[SET_W-1:0];
  endfunction

  function automatic logic [WAY_W-1:0] way_mod(input logic [WAY_IN_W-1:0] x);
    logic [10:0] r;
    r = 11'(x);
    for (int k = WAY_IN_W - 1; k >= 0; k--) begin
      if (r >= (11'(NUM_WAYS) << k)) r = r - (11'(NUM_WAYS) << k);
    end
    return r[WAY_W-1:0];
  endfunction

  // memories
  rrpv_row_t          rrpv_mem  [NUM_SETS];
  reuse_row_t         reuse_mem [NUM_SETS];
  sig_row_t           sig_mem   [NUM_SETS];
  logic [1:0]         pred_mem  [PRED_N];

  // item and row registers
  logic                kind_q, hit_q;
  logic [SET_W-1:0]    set_q;
  logic [WAY_W-1:0]    way_q;
  logic [SIG_BITS-1:0] sig_q;
  rrpv_row_t           rrpv_q;
  reuse_row_t          reuse_q;
  sig_row_t            lsig_q;
  logic [1:0]          pred_q;
  logic [WAY_W-1:0]    vway_q;
  logic                vreuse_q;
  logic [SIG_BITS-1:0] psig_q;

  // control state
  logic [CLR_W-1:0]    clr_q;
  logic [1:0]          thr_q, thr_d;
  logic [EPOCH_W-1:0]  cnt_q, cnt_d, hits_q, hits_d, prev_q, prev_d, len_q;
  logic                out_valid_q;
  logic [3:0]          out_vway_q;
  logic [1:0]          out_thr_q;

  logic [SIG_BITS-1:0] in_sig;
  logic [SIG_BITS-1:0] pred_rd_addr;
  logic                pred_rd_en;
  rrpv_row_t           aged;
  logic [WAY_W-1:0]    vway;
  rrpv_row_t           rrpv_n;
  reuse_row_t          reuse_n;
  sig_row_t            sig_n;
  logic [1:0]          pred_n;
  logic [EPOCH_W-1:0]  cnt_inc, hits_inc;

  assign in_sig = SIG_BITS'(pc_signature_i);

  // ageing: add the same amount to every way until one is distant
  always_comb begin
    logic [1:0] top;
    top = RRPV_NEAR;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (rrpv_q[w] > top) top = rrpv_q[w];
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      aged[w] = rrpv_q[w] + (RRPV_DISTANT - top);
    end
  end

  // lowest distant way
  always_comb begin
    vway = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (aged[w] == RRPV_DISTANT) vway = WAY_W'(w);
    end
  end

  // new row contents
  always_comb begin
    rrpv_n  = rrpv_q;
    reuse_n = reuse_q;
    sig_n   = lsig_q;
    if (kind_q == KIND_VICTIM) begin
      rrpv_n        = aged;
      reuse_n[vway] = 1'b0;
      sig_n[vway]   = '0;
    end else if (hit_q) begin
      rrpv_n[way_q]  = RRPV_NEAR;
      reuse_n[way_q] = 1'b1;
    end else begin
      rrpv_n[way_q]  = (pred_q >= thr_q) ? RRPV_LONG : RRPV_DISTANT;
      reuse_n[way_q] = 1'b0;
      sig_n[way_q]   = sig_q;
    end
  end

  // predictor training
  always_comb begin
    pred_n = pred_q;
    if (vreuse_q) begin
      if (pred_q != PRED_TOP) pred_n = pred_q + 2'd1;
    end else if (pred_q != PRED_BOTTOM) begin
      pred_n = pred_q - 2'd1;
    end
  end

  // epoch adaptation
  assign cnt_inc  = cnt_q + EPOCH_W'(1);
  assign hits_inc = hits_q + EPOCH_W'(hit_q);

  always_comb begin
    thr_d  = thr_q;
    cnt_d  = cnt_inc;
    hits_d = hits_inc;
    prev_d = prev_q;
    if (cnt_inc >= len_q) begin
      if (hits_inc < prev_q) begin
        if (thr_q != PRED_TOP) thr_d = thr_q + 2'd1;
      end else if (thr_q != PRED_BOTTOM) begin
        thr_d = thr_q - 2'd1;
      end
      prev_d = hits_inc;
      cnt_d  = '0;
      hits_d = '0;
    end
  end

  // set metadata memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear && ({1'b0, clr_q} < CLR_SETS)) begin
      rrpv_mem[clr_q[SET_W-1:0]]  <= {NUM_WAYS{RRPV_DISTANT}};
      reuse_mem[clr_q[SET_W-1:0]] <= '0;
      sig_mem[clr_q[SET_W-1:0]]   <= '0;
    end else if (cmd_i.row_step) begin
      rrpv_mem[set_q]  <= rrpv_n;
      reuse_mem[set_q] <= reuse_n;
      sig_mem[set_q]   <= sig_n;
    end
    if (cmd_i.accept) begin
      rrpv_q  <= rrpv_mem[set_mod(set_index_i)];
      reuse_q <= reuse_mem[set_mod(set_index_i)];
      lsig_q  <= sig_mem[set_mod(set_index_i)];
    end
  end

  // predictor memory
  assign pred_rd_en   = cmd_i.accept || (cmd_i.row_step && (kind_q == KIND_VICTIM));
  assign pred_rd_addr = cmd_i.accept ? in_sig : lsig_q[vway];

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      pred_mem[clr_q[SIG_BITS-1:0]] <= PRED_START;
    end else if (cmd_i.pred_step) begin
      pred_mem[psig_q] <= pred_n;
    end
    if (pred_rd_en) begin
      pred_q <= pred_mem[pred_rd_addr];
    end
  end

  // item payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= kind_i;
      hit_q  <= hit_i;
      set_q  <= set_mod(set_index_i);
      way_q  <= way_mod(way_i);
      sig_q  <= in_sig;
    end
    if (cmd_i.row_step) begin
      vway_q   <= (kind_q == KIND_VICTIM) ? vway : '0;
      vreuse_q <= reuse_q[vway];
      psig_q   <= lsig_q[vway];
    end
    if (cmd_i.load_out) begin
      out_vway_q <= 4'(vway_q);
      out_thr_q  <= thr_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      thr_q       <= THR_RESET;
      cnt_q       <= '0;
      hits_q      <= '0;
      prev_q      <= '0;
      len_q       <= EPOCH_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) clr_q <= clr_q + CLR_W'(1);
      if (cfg_valid_i) len_q <= cfg_epoch_length_i;
      if (cmd_i.row_step && (kind_q == KIND_UPDATE)) begin
        thr_q  <= thr_d;
        cnt_q  <= cnt_d;
        hits_q <= hits_d;
        prev_q <= prev_d;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.clear_last = (clr_q == CLR_LAST);
  assign sts_o.is_victim  = (kind_q == KIND_VICTIM);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign victim_way_o = out_vway_q;
  assign threshold_o  = out_thr_q;

endmodule

/* hdl/rrip_replacement_with_reuse_predictor_core.sv */
// ----------------------------------------------------------------------------
// rrip_replacement_with_reuse_predictor_core
// SRRIP replacement with a signature-indexed reuse predictor and an
// epoch-adapted insertion threshold.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): one transfer per item, either a
//   victim request or a hit/fill update for a set and way.
//   Output channel (out_valid_o / out_stall_i): one transfer per item with
//   the victim way (0 for updates) and the threshold after the item.
//   Configuration channel (cfg_valid_i / cfg_ready_o, always ready): writes
//   the epoch length; write only while the block is idle.
// Timing: each item passes through the set-row read-modify-write and, for
//   victim requests, the dependent predictor read-modify-write on the
//   single-port tables before its result enters the output register. The
//   next item is taken at the earliest on the cycle after the result enters
//   the output register.
// Reset: the RRPV, reuse, signature and predictor tables are cleared by a
//   sweep over max(NUM_SETS, 2**SIG_BITS) addresses (32768 by default),
//   during which in_stall_o stays high.
// A stalled result stays in the output register; the block keeps working on
//   one more item and holds its result until the register frees.
// ----------------------------------------------------------------------------
module rrip_replacement_with_reuse_predictor_core #(
  parameter int unsigned NUM_SETS = rrip_pkg::NUM_SETS_DEF,
  parameter int unsigned NUM_WAYS = rrip_pkg::NUM_WAYS_DEF,
  parameter int unsigned SIG_BITS = rrip_pkg::SIG_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [rrip_pkg::SET_IN_W-1:0] set_index_i,
  input  logic [rrip_pkg::WAY_IN_W-1:0] way_i,
  input  logic                          hit_i,
  input  logic [rrip_pkg::PC_IN_W-1:0]  pc_signature_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [3:0]                    victim_way_o,
  output logic [1:0]                    threshold_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rrip_pkg::EPOCH_W-1:0]  cfg_epoch_length_i
);
  import rrip_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  rrip_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rrip_datapath #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS),
    .SIG_BITS (SIG_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .kind_i             (kind_i),
    .set_index_i        (set_index_i),
    .way_i              (way_i),
    .hit_i              (hit_i),
    .pc_signature_i     (pc_signature_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_epoch_length_i (cfg_epoch_length_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .victim_way_o       (victim_way_o),
    .threshold_o        (threshold_o)
  );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the RRIP replacement core with reuse predictor.
// A directed table is followed by phases of random victim requests, fills
// and hits, each phase under its own epoch length. A behavioural copy of the
// replacement state predicts the untyped results. Both channel sides idle
// and stall at random, with one long receiver hold-off and one sender drain.
// ----------------------------------------------------------------------------
module testbench;
  import rrip_pkg::*;

  localparam int unsigned LINES      = NUM_SETS_DEF * NUM_WAYS_DEF;
  localparam int unsigned PREDS      = 1 << SIG_BITS_DEF;
  localparam int unsigned LIMIT      = 600000;
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned PHASE_ITEMS = 150;
  localparam int unsigned DRAIN_WAIT = 8;

  typedef struct {
    logic                kind;
    logic [SET_IN_W-1:0] set_idx;
    logic [WAY_IN_W-1:0] way;
    logic                hit;
    logic [PC_IN_W-1:0]  pc;
  } access_t;

  typedef struct {
    logic [3:0] victim;
    logic [1:0] thr;
  } outcome_t;

  typedef struct {
    access_t  acc;
    logic     typed;
    outcome_t res;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 kind_i;
  logic [SET_IN_W-1:0]  set_index_i;
  logic [WAY_IN_W-1:0]  way_i;
  logic                 hit_i;
  logic [PC_IN_W-1:0]   pc_signature_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [3:0]           victim_way_o;
  logic [1:0]           threshold_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [EPOCH_W-1:0]   cfg_epoch_length_i;

  rrip_replacement_with_reuse_predictor_core u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .kind_i             (kind_i),
    .set_index_i        (set_index_i),
    .way_i              (way_i),
    .hit_i              (hit_i),
    .pc_signature_i     (pc_signature_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .victim_way_o       (victim_way_o),
    .threshold_o        (threshold_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_epoch_length_i (cfg_epoch_length_i)
  );

  // shadow replacement state
  logic [1:0]           rrpv_q    [LINES];
  logic                 reused_q  [LINES];
  logic [PC_IN_W-1:0]   line_sig_q[LINES];
  logic [1:0]           pred_q    [PREDS];
  logic [1:0]           thr_q;
  logic [EPOCH_W-1:0]   upd_cnt_q;
  logic [EPOCH_W-1:0]   hit_cnt_q;
  logic [EPOCH_W-1:0]   prev_hits_q;
  logic [EPOCH_W-1:0]   epoch_len_q;

  outcome_t pending_q[$];
  int unsigned errors = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit idle_en;
  bit hold_req;

  logic [SET_IN_W-1:0] hot_sets[4] = '{11'd0, 11'd1, 11'd1023, 11'd2047};
  logic [PC_IN_W-1:0]  hot_pcs [6] = '{15'h0000, 15'h0001, 15'h1234, 15'h2aaa,
                                       15'h5555, 15'h7fff};

  // directed table: typed results only where they follow at once from reset
  dir_row_t dir_rows[14] = '{
    '{'{KIND_VICTIM, 11'd0,    4'd0,  1'b0, 15'h0000}, 1'b1, '{4'd0, 2'd2}},
    '{'{KIND_VICTIM, 11'd2047, 4'd15, 1'b1, 15'h7fff}, 1'b1, '{4'd0, 2'd2}},
    '{'{KIND_UPDATE, 11'd0,    4'd0,  1'b0, 15'h0000}, 1'b1, '{4'd0, 2'd2}},
    '{'{KIND_VICTIM, 11'd0,    4'd0,  1'b0, 15'h0000}, 1'b1, '{4'd0, 2'd2}},
    '{'{KIND_UPDATE, 11'd0,    4'd15, 1'b0, 15'h0000}, 1'b1, '{4'd0, 2'd2}},
    '{'{KIND_UPDATE, 11'd0,    4'd15, 1'b1, 15'h0000}, 1'b0, '{4'd0, 2'd0}},
    '{'{KIND_UPDATE, 11'd2047, 4'd15, 1'b0, 15'h7fff}, 1'b1, '{4'd0, 2'd2}},
    '{'{KIND_UPDATE, 11'd2047, 4'd15, 1'b1, 15'h7fff}, 1'b0, '{4'd0, 2'd0}},
    '{'{KIND_UPDATE, 11'd5,    4'd3,  1'b0, 15'h5555}, 1'b0, '{4'd0, 2'd0}},
    '{'{KIND_UPDATE, 11'h2aa,  4'd10, 1'b1, 15'h2aaa}, 1'b0, '{4'd0, 2'd0}},
    '{'{KIND_VICTIM, 11'd2047, 4'd0,  1'b0, 15'h0000}, 1'b0, '{4'd0, 2'd0}},
    '{'{KIND_VICTIM, 11'd0,    4'd7,  1'b1, 15'h1234}, 1'b0, '{4'd0, 2'd0}},
    '{'{KIND_UPDATE, 11'd0,    4'd1,  1'b1, 15'h0000}, 1'b0, '{4'd0, 2'd0}},
    '{'{KIND_VICTIM, 11'd0,    4'd0,  1'b0, 15'h0000}, 1'b0, '{4'd0, 2'd0}}
  };

  // epoch lengths per random phase: extremes, zero and short epochs
  logic [EPOCH_W-1:0] phase_len[8] = '{21'd1, 21'd3, 21'd0, 21'd7, 21'd1048576,
                                       21'h1fffff, 21'd5, 21'd2};

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // replacement behaviour for one accepted access
  function automatic outcome_t replace_step(access_t a);
    outcome_t   o;
    int unsigned base;
    int unsigned line;
    logic [1:0] top;
    logic [1:0] add;
    logic [PC_IN_W-1:0] ls;
    base = int'(a.set_idx) * NUM_WAYS_DEF;
    o.victim = '0;
    if (a.kind == KIND_VICTIM) begin
      top = '0;
      for (int w = 0; w < NUM_WAYS_DEF; w++)
        if (rrpv_q[base+w] > top) top = rrpv_q[base+w];
      add = RRPV_DISTANT - top;
      for (int w = 0; w < NUM_WAYS_DEF; w++) rrpv_q[base+w] += add;
      for (int w = NUM_WAYS_DEF - 1; w >= 0; w--)
        if (rrpv_q[base+w] == RRPV_DISTANT) o.victim = 4'(w);
      line = base + o.victim;
      ls = line_sig_q[line];
      if (reused_q[line]) begin
        if (pred_q[ls] < PRED_TOP) pred_q[ls]++;
      end else if (pred_q[ls] > PRED_BOTTOM) begin
        pred_q[ls]--;
      end
      reused_q[line]   = 1'b0;
      line_sig_q[line] = '0;
    end else begin
      line = base + a.way;
      if (a.hit) begin
        rrpv_q[line]   = RRPV_NEAR;
        reused_q[line] = 1'b1;
      end else begin
        line_sig_q[line] = a.pc;
        reused_q[line]   = 1'b0;
        rrpv_q[line]     = (pred_q[a.pc] >= thr_q) ? RRPV_LONG : RRPV_DISTANT;
      end
      // epoch bookkeeping and threshold adaptation
      upd_cnt_q++;
      if (a.hit) hit_cnt_q++;
      if (upd_cnt_q >= epoch_len_q) begin
        if (hit_cnt_q < prev_hits_q) begin
          if (thr_q < PRED_TOP) thr_q++;
        end else if (thr_q > 2'd0) begin
          thr_q--;
        end
        prev_hits_q = hit_cnt_q;
        upd_cnt_q   = '0;
        hit_cnt_q   = '0;
      end
    end
    o.thr = thr_q;
    return o;
  endfunction

  // random access: mostly hot sets and signatures, some full-range noise
  function automatic access_t random_access();
    access_t     a;
    int unsigned r;
    r = $urandom_range(99);
    a.kind    = (r < 30) ? KIND_VICTIM : KIND_UPDATE;
    a.hit     = (r >= 60);
    a.way     = WAY_IN_W'($urandom_range(15));
    a.set_idx = ($urandom_range(9) < 8) ? hot_sets[$urandom_range(3)]
                                        : SET_IN_W'($urandom());
    a.pc      = ($urandom_range(9) < 7) ? hot_pcs[$urandom_range(5)]
                                        : PC_IN_W'($urandom());
    return a;
  endfunction

  // offer one access and wait for its transfer
  task automatic send_access(access_t a, logic typed, outcome_t typed_res);
    outcome_t o;
    if (idle_en && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= a.kind;
    set_index_i    <= a.set_idx;
    way_i          <= a.way;
    hit_i          <= a.hit;
    pc_signature_i <= a.pc;
    do @(posedge clk_i); while (in_stall_o);
    o = replace_step(a);
    pending_q.push_back(typed ? typed_res : o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_epoch_length(logic [EPOCH_W-1:0] len);
    wait_drained();
    cfg_valid_i        <= 1'b1;
    cfg_epoch_length_i <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    epoch_len_q = len;
  endtask

  // result receiver: random stalls plus one long hold-off on request
  initial begin
    bit hold_done;
    hold_done   = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk_i);
        hold_done = 1'b1;
      end
      out_stall_i <= idle_en && ($urandom_range(99) < 7);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    outcome_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10)
          $display("unexpected result victim=%0d thr=%0d", victim_way_o, threshold_o);
      end else begin
        e = pending_q.pop_front();
        if (victim_way_o !== e.victim || threshold_o !== e.thr) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch: victim exp %0d got %0d, thr exp %0d got %0d",
                     e.victim, victim_way_o, e.thr, threshold_o);
        end
      end
    end
  end

  // main sequence
  initial begin
    outcome_t none;
    none = '{4'd0, 2'd0};
    idle_en = 1'b1; hold_req = 1'b0;
    rst_ni = 1'b0; in_valid_i = 1'b0; kind_i = 1'b0; set_index_i = '0;
    way_i = '0; hit_i = 1'b0; pc_signature_i = '0;
    cfg_valid_i = 1'b0; cfg_epoch_length_i = '0;
    for (int i = 0; i < LINES; i++) begin
      rrpv_q[i] = RRPV_DISTANT; reused_q[i] = 1'b0; line_sig_q[i] = '0;
    end
    for (int i = 0; i < PREDS; i++) pred_q[i] = PRED_START;
    thr_q = THR_RESET; upd_cnt_q = '0; hit_cnt_q = '0; prev_hits_q = '0;
    epoch_len_q = EPOCH_RESET;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_access(dir_rows[i].acc, dir_rows[i].typed, dir_rows[i].res);

    foreach (phase_len[p]) begin
      write_epoch_length(phase_len[p]);
      idle_en = (p != 3);
      if (p == 1) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // sender drain halfway through one phase
        if (p == 4 && n == PHASE_ITEMS / 2) wait_drained();
        send_access(random_access(), 1'b0, none);
      end
    end

    wait_drained();
    idle_en = 1'b1;
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* rrip_replacement_with_reuse_predictor_core.f */
hdl/rrip_pkg.sv
hdl/rrip_ctrl.sv
hdl/rrip_datapath.sv
hdl/rrip_replacement_with_reuse_predictor_core.sv
tb/testbench.sv
